>>> sv/nfba_pkg.sv
// Package for the next-fit block allocator.
// Holds field widths, command codes and the sequencer state type; no dependencies.
package nfba_pkg;

  localparam int CMD_W    = 1;
  localparam int SEL_W    = 4;
  localparam int VAL_W    = 16;
  localparam int ACTIVE_W = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CMP,
    ST_DONE
  } nfba_state_t;

endpackage

>>> sv/nfba_if.sv
// Valid/ready channel interfaces for the allocator's command and result streams.
// Depends on nfba_pkg for the field widths.
interface nfba_in_if;
  import nfba_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SEL_W-1:0] block_select;
  logic [VAL_W-1:0] size_value;

  modport source (output valid, command, block_select, size_value, input ready);
  modport sink   (input valid, command, block_select, size_value, output ready);
endinterface

interface nfba_out_if;
  import nfba_pkg::*;

  logic             valid;
  logic             ready;
  logic             placed;
  logic [SEL_W-1:0] chosen_block;
  logic [VAL_W-1:0] size_before;

  modport source (output valid, placed, chosen_block, size_before, input ready);
  modport sink   (input valid, placed, chosen_block, size_before, output ready);
endinterface

>>> sv/next_fit_block_allocator.sv
// Next-fit block allocator: a free-size memory scanned circularly from a roving position.
// Depends on nfba_pkg and the channel interfaces in nfba_if.sv.
//
// A load gives no result. An allocate passes through the MOD state, which reduces the
// start position taken from the rover by the active count as often as needed when that
// count was lowered below it, then READ and CMP, where from one block up to the active
// block count are compared, then DONE; with no active blocks it goes straight to DONE after the
// transfer. The result is then held until transferred. One compare/subtract
// unit checks one block per cycle, fed by the single read port of the free-size memory.
module next_fit_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  nfba_in_if.sink                       in_chan,
  nfba_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [nfba_pkg::ACTIVE_W-1:0] cfg_wdata
);
  import nfba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam logic [CMP_W-1:0] NUM_BLOCKS_C = CMP_W'(NUM_BLOCKS);

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];

  nfba_state_t          state_r, state_nxt;
  logic [ACTIVE_W-1:0]  active_r;
  logic [IDX_W-1:0]     rover_r, rover_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     scanned_r, scanned_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 placed_r, placed_nxt;
  logic [SEL_W-1:0]     chosen_r, chosen_nxt;
  logic [VAL_W-1:0]     before_r, before_nxt;

  logic                 in_xfer, out_xfer;
  logic [CMP_W-1:0]     active_ext;
  logic [CNT_W-1:0]     cnt_sat;
  logic [SIZE_BITS-1:0] in_val;
  logic [IDX_W-1:0]     in_idx;
  logic                 sel_ok;
  logic                 rover_high;
  logic                 fit;
  logic                 last;
  logic [IDX_W-1:0]     idx_inc;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;

  // Active count saturates at the table depth.
  assign active_ext = CMP_W'(active_r);
  assign cnt_sat    = (active_ext > NUM_BLOCKS_C) ? CNT_W'(NUM_BLOCKS) : CNT_W'(active_ext);

  assign in_val = SIZE_BITS'(in_chan.size_value);
  assign in_idx = IDX_W'(in_chan.block_select);
  assign sel_ok = CMP_W'(in_chan.block_select) < NUM_BLOCKS_C;

  assign rover_high = CNT_W'(idx_r) >= cnt_r;

  // Shared compare/subtract unit works on the entry read last cycle.
  assign fit     = rd_data_r >= req_r;
  assign last    = (scanned_r + CNT_W'(1)) == cnt_r;
  assign idx_inc = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r) ? '0 : idx_r + IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_chan.command == CMD_ALLOC) begin
          state_nxt = (cnt_sat == '0) ? ST_DONE : ST_MOD;
        end
      end
      ST_MOD: begin
        if (!rover_high) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_CMP;
      ST_CMP: begin
        if (fit || last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_xfer) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rover_nxt   = rover_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    scanned_nxt = scanned_r;
    req_nxt     = req_r;
    placed_nxt  = placed_r;
    chosen_nxt  = chosen_r;
    before_nxt  = before_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = rd_data_r - req_r;
    mem_raddr   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.command == CMD_LOAD) begin
            mem_we    = sel_ok;
            mem_waddr = in_idx;
            mem_wdata = in_val;
            rover_nxt = '0;
          end else begin
            req_nxt     = in_val;
            idx_nxt     = rover_r;
            cnt_nxt     = cnt_sat;
            scanned_nxt = '0;
            placed_nxt  = 1'b0;
            chosen_nxt  = '0;
            before_nxt  = '0;
          end
        end
      end
      ST_MOD: begin
        // Reduce the start position into the active range.
        if (rover_high) begin
          idx_nxt = IDX_W'(CNT_W'(idx_r) - cnt_r);
        end
      end
      ST_CMP: begin
        if (fit) begin
          mem_we     = 1'b1;
          rover_nxt  = idx_r;
          placed_nxt = 1'b1;
          chosen_nxt = SEL_W'(idx_r);
          before_nxt = VAL_W'(rd_data_r);
        end else begin
          // Fetch the next block while this one is compared.
          idx_nxt     = idx_inc;
          scanned_nxt = scanned_r + CNT_W'(1);
          mem_raddr   = idx_inc;
        end
      end
      default: ;
    endcase
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = (state_r == ST_DONE);
  assign out_chan.placed       = placed_r;
  assign out_chan.chosen_block = chosen_r;
  assign out_chan.size_before  = before_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rover_r  <= '0;
      active_r <= ACTIVE_RST;
    end else begin
      state_r <= state_nxt;
      rover_r <= rover_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    scanned_r <= scanned_nxt;
    req_r     <= req_nxt;
    placed_r  <= placed_nxt;
    chosen_r  <= chosen_nxt;
    before_r  <= before_nxt;
  end

endmodule
